// ===== hdl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants, codes and types of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int PIXEL_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = 24;
    localparam int NUM_PTS   = 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam int DEC_INIT      = 3;
    localparam int DEC_STEP_DIAG = 10;
    localparam int DEC_STEP_AXIS = 6;
    localparam int DEC_GAIN_SH   = 2;

    typedef enum logic {
        KIND_START   = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
    } t_cfg;

endpackage

// ===== hdl/mcr_if.sv =====
// ----------------------------------------------------------------------------
// mcr_if
// Valid/ready channels of the rasterizer: input words, point sets, config.
// ----------------------------------------------------------------------------
interface mcr_in_if #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS,
    parameter int PIXEL_BITS = mcr_pkg::PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
    logic [PIXEL_BITS-1:0] color;

    modport source (output valid, kind, center_x, center_y, radius, color, input ready);
    modport sink   (input valid, kind, center_x, center_y, radius, color, output ready);
endinterface

interface mcr_out_if #(
    parameter int PIXEL_BITS = mcr_pkg::PIXEL_BITS
);
    logic                          valid;
    logic                          ready;
    logic [mcr_pkg::ADDR_W-1:0]    addr_a;
    logic [mcr_pkg::ADDR_W-1:0]    addr_b;
    logic [mcr_pkg::ADDR_W-1:0]    addr_c;
    logic [mcr_pkg::ADDR_W-1:0]    addr_d;
    logic [mcr_pkg::ADDR_W-1:0]    addr_e;
    logic [mcr_pkg::ADDR_W-1:0]    addr_f;
    logic [mcr_pkg::ADDR_W-1:0]    addr_g;
    logic [mcr_pkg::ADDR_W-1:0]    addr_h;
    logic [PIXEL_BITS-1:0]         pixel_value;
    logic [mcr_pkg::NUM_PTS-1:0]   clip_mask;
    logic                          last_step;

    modport source (output valid, addr_a, addr_b, addr_c, addr_d, addr_e, addr_f, addr_g,
                    addr_h, pixel_value, clip_mask, last_step, input ready);
    modport sink   (input valid, addr_a, addr_b, addr_c, addr_d, addr_e, addr_f, addr_g,
                    addr_h, pixel_value, clip_mask, last_step, output ready);
endinterface

interface mcr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mcr_pkg::CFG_IDX_W-1:0] index;
    logic [mcr_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front
// Takes input words, runs the midpoint decision recurrence and pushes one
// point job per emitted point set.
// ----------------------------------------------------------------------------
module mcr_front #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS,
    parameter int PIXEL_BITS = mcr_pkg::PIXEL_BITS,
    parameter int JOB_W      = 2 * COORD_BITS + 2 * (COORD_BITS + 1) + PIXEL_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mcr_in_if.sink           i_in,
    output logic             o_job_valid,
    output logic [JOB_W-1:0] o_job,
    input  logic             i_job_ready
);

    localparam int OFS_W = COORD_BITS + 1;
    localparam int DEC_W = COORD_BITS + 6;

    logic                         r_busy, n_busy;
    logic signed [OFS_W-1:0]      r_ofs_x, n_ofs_x;
    logic signed [OFS_W-1:0]      r_ofs_y, n_ofs_y;
    logic signed [DEC_W-1:0]      r_dec, n_dec;
    logic [COORD_BITS-1:0]        r_org_x, n_org_x;
    logic [COORD_BITS-1:0]        r_org_y, n_org_y;
    logic [PIXEL_BITS-1:0]        r_color, n_color;
    logic                         n_last;
    logic                         accept;
    logic signed [DEC_W-1:0]      rad_ext;
    logic signed [OFS_W-1:0]      ofs_x_inc;
    logic signed [OFS_W-1:0]      ofs_y_dec;
    logic signed [DEC_W-1:0]      step_x;
    logic signed [DEC_W-1:0]      step_xy;

    assign i_in.ready = i_job_ready;
    assign accept     = i_in.valid && i_job_ready;

    assign rad_ext   = $signed({{(DEC_W - COORD_BITS){1'b0}}, i_in.radius});
    assign ofs_x_inc = r_ofs_x + OFS_W'(1);
    assign ofs_y_dec = r_ofs_y - OFS_W'(1);
    assign step_x    = DEC_W'(ofs_x_inc);
    assign step_xy   = DEC_W'(ofs_x_inc) - DEC_W'(ofs_y_dec);

    always_comb begin
        n_busy      = r_busy;
        n_ofs_x     = r_ofs_x;
        n_ofs_y     = r_ofs_y;
        n_dec       = r_dec;
        n_org_x     = r_org_x;
        n_org_y     = r_org_y;
        n_color     = r_color;
        n_last      = 1'b0;
        o_job_valid = 1'b0;
        if (i_in.kind == mcr_pkg::KIND_START) begin
            n_org_x     = i_in.center_x;
            n_org_y     = i_in.center_y;
            n_color     = i_in.color;
            n_ofs_x     = '0;
            n_ofs_y     = $signed({1'b0, i_in.radius});
            n_dec       = DEC_W'(mcr_pkg::DEC_INIT) - (rad_ext <<< 1);
            n_busy      = 1'b1;
            o_job_valid = i_in.valid;
        end else if (r_busy) begin
            n_ofs_x = ofs_x_inc;
            if (r_dec > DEC_W'(0)) begin
                n_ofs_y = ofs_y_dec;
                n_dec   = r_dec + (step_xy <<< mcr_pkg::DEC_GAIN_SH)
                          + DEC_W'(mcr_pkg::DEC_STEP_DIAG);
            end else begin
                n_dec   = r_dec + (step_x <<< mcr_pkg::DEC_GAIN_SH)
                          + DEC_W'(mcr_pkg::DEC_STEP_AXIS);
            end
            n_last      = n_ofs_y < n_ofs_x;
            n_busy      = !n_last;
            o_job_valid = i_in.valid;
        end
    end

    assign o_job = {n_org_x, n_org_y, n_ofs_x, n_ofs_y, n_color, n_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ofs_x <= '0;
            r_ofs_y <= '0;
            r_dec   <= '0;
            r_org_x <= '0;
            r_org_y <= '0;
            r_color <= '0;
        end else if (accept) begin
            r_busy  <= n_busy;
            r_ofs_x <= n_ofs_x;
            r_ofs_y <= n_ofs_y;
            r_dec   <= n_dec;
            r_org_x <= n_org_x;
            r_org_y <= n_org_y;
            r_color <= n_color;
        end
    end

endmodule

// ===== hdl/mcr_queue.sv =====
// ----------------------------------------------------------------------------
// mcr_queue
// Small register queue between the recurrence and the address pipeline.
// ----------------------------------------------------------------------------
module mcr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hdl/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back
// Three-stage address pipeline: symmetric points and clip test, row
// multiply, column add into the output register.
// ----------------------------------------------------------------------------
module mcr_back #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS,
    parameter int PIXEL_BITS = mcr_pkg::PIXEL_BITS,
    parameter int JOB_W      = 2 * COORD_BITS + 2 * (COORD_BITS + 1) + PIXEL_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mcr_pkg::t_cfg    i_cfg,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  logic [JOB_W-1:0] i_job,
    mcr_out_if.source        o_out
);

    localparam int OFS_W  = COORD_BITS + 1;
    localparam int SUM_W  = COORD_BITS + 3;
    localparam int CFG_W  = mcr_pkg::CFG_W;
    localparam int ADDR_W = mcr_pkg::ADDR_W;
    localparam int NPT    = mcr_pkg::NUM_PTS;
    localparam int CMP_W  = (SUM_W > CFG_W) ? SUM_W : CFG_W;
    localparam int PRD_W  = 2 * CFG_W;

    localparam int LAST_POS = 0;
    localparam int COL_LO   = 1;
    localparam int Y_LO     = COL_LO + PIXEL_BITS;
    localparam int X_LO     = Y_LO + OFS_W;
    localparam int CY_LO    = X_LO + OFS_W;
    localparam int CX_LO    = CY_LO + COORD_BITS;

    // column and row selector of each of the eight points, two bits each, point a lowest
    localparam logic [2*NPT-1:0] COL_SEL = {2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0};
    localparam logic [2*NPT-1:0] ROW_SEL = {2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};

    logic signed [SUM_W-1:0] cx, cy, ox, oy;
    logic signed [SUM_W-1:0] col [4];
    logic signed [SUM_W-1:0] row [4];
    logic [3:0]              col_out, row_out;
    logic [NPT-1:0]          mask;
    logic [PRD_W-1:0]        prod [4];
    logic [ADDR_W-1:0]       addr [NPT];

    logic                    en1, en2, en3;

    logic                    r1_v;
    logic [CFG_W-1:0]        r1_col [4];
    logic [CFG_W-1:0]        r1_row [4];
    logic [NPT-1:0]          r1_mask;
    logic [PIXEL_BITS-1:0]   r1_color;
    logic                    r1_last;

    logic                    r2_v;
    logic [CFG_W-1:0]        r2_col [4];
    logic [ADDR_W-1:0]       r2_prod [4];
    logic [NPT-1:0]          r2_mask;
    logic [PIXEL_BITS-1:0]   r2_color;
    logic                    r2_last;

    logic                    r3_v;
    logic [ADDR_W-1:0]       r3_addr [NPT];
    logic [NPT-1:0]          r3_mask;
    logic [PIXEL_BITS-1:0]   r3_color;
    logic                    r3_last;

    assign en3         = !r3_v || o_out.ready;
    assign en2         = !r2_v || en3;
    assign en1         = !r1_v || en2;
    assign o_job_ready = en1;

    assign cx = $signed({{(SUM_W - COORD_BITS){1'b0}}, i_job[CX_LO +: COORD_BITS]});
    assign cy = $signed({{(SUM_W - COORD_BITS){1'b0}}, i_job[CY_LO +: COORD_BITS]});
    assign ox = SUM_W'($signed(i_job[X_LO +: OFS_W]));
    assign oy = SUM_W'($signed(i_job[Y_LO +: OFS_W]));

    assign col[0] = cx + ox;
    assign col[1] = cx - ox;
    assign col[2] = cx + oy;
    assign col[3] = cx - oy;
    assign row[0] = cy + oy;
    assign row[1] = cy - oy;
    assign row[2] = cy + ox;
    assign row[3] = cy - ox;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            col_out[k] = col[k][SUM_W-1]
                         || (CMP_W'(col[k][SUM_W-2:0]) >= CMP_W'(i_cfg.image_width));
            row_out[k] = row[k][SUM_W-1]
                         || (CMP_W'(row[k][SUM_W-2:0]) >= CMP_W'(i_cfg.image_height));
        end
        for (int i = 0; i < NPT; i++) begin
            mask[i] = col_out[COL_SEL[2*i +: 2]] || row_out[ROW_SEL[2*i +: 2]];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = PRD_W'(r1_row[k]) * PRD_W'(i_cfg.image_width);
        end
    end

    always_comb begin
        for (int i = 0; i < NPT; i++) begin
            addr[i] = r2_mask[i] ? '0
                      : r2_prod[ROW_SEL[2*i +: 2]] + ADDR_W'(r2_col[COL_SEL[2*i +: 2]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_job_valid;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int k = 0; k < 4; k++) begin
                r1_col[k] <= col[k][CFG_W-1:0];
                r1_row[k] <= row[k][CFG_W-1:0];
            end
            r1_mask  <= mask;
            r1_color <= i_job[COL_LO +: PIXEL_BITS];
            r1_last  <= i_job[LAST_POS];
        end
        if (en2) begin
            for (int k = 0; k < 4; k++) begin
                r2_col[k]  <= r1_col[k];
                r2_prod[k] <= prod[k][ADDR_W-1:0];
            end
            r2_mask  <= r1_mask;
            r2_color <= r1_color;
            r2_last  <= r1_last;
        end
        if (en3) begin
            for (int i = 0; i < NPT; i++) begin
                r3_addr[i] <= addr[i];
            end
            r3_mask  <= r2_mask;
            r3_color <= r2_color;
            r3_last  <= r2_last;
        end
    end

    assign o_out.valid       = r3_v;
    assign o_out.addr_a      = r3_addr[0];
    assign o_out.addr_b      = r3_addr[1];
    assign o_out.addr_c      = r3_addr[2];
    assign o_out.addr_d      = r3_addr[3];
    assign o_out.addr_e      = r3_addr[4];
    assign o_out.addr_f      = r3_addr[5];
    assign o_out.addr_g      = r3_addr[6];
    assign o_out.addr_h      = r3_addr[7];
    assign o_out.pixel_value = r3_color;
    assign o_out.clip_mask   = r3_mask;
    assign o_out.last_step   = r3_last;

endmodule

// ===== hdl/midpoint_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle rasterizer emitting one eight-way point set per word.
// ----------------------------------------------------------------------------
// i_in takes command words: kind start loads center, radius and color and
// yields the first point set; kind advance yields the next octant step, or
// nothing when no circle is running. o_out gives one word per point set:
// eight frame buffer addresses (row * image_width + column), the color, a
// clip mask for points off the image (their address reads zero) and
// last_step on the set that ends the circle. i_cfg writes image_width and
// image_height; it is always ready and is meant for use while idle.
// One command word per cycle is taken while i_in.ready is high. A point set
// passes the queue and then the address pipeline: a clip stage, a row
// multiply stage and the column add into the output register.
// A two-word queue sits between the decision recurrence and that pipeline.
// When o_out stalls, the pipeline and queue fill and i_in.ready drops; no
// word is lost. Reset empties the queue and pipeline, ends any running
// circle and sets the image to 640 by 480.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS,
    parameter int PIXEL_BITS = mcr_pkg::PIXEL_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcr_in_if.sink    i_in,
    mcr_out_if.source o_out,
    mcr_cfg_if.sink   i_cfg
);

    localparam int JOB_W = 2 * COORD_BITS + 2 * (COORD_BITS + 1) + PIXEL_BITS + 1;

    mcr_pkg::t_cfg    r_cfg;
    logic             push_valid, push_ready;
    logic [JOB_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [JOB_W-1:0] pop_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= mcr_pkg::WIDTH_RESET;
            r_cfg.image_height <= mcr_pkg::HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mcr_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg.data;
                mcr_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mcr_front #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (push_valid),
        .o_job       (push_data),
        .i_job_ready (push_ready)
    );

    mcr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (mcr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    mcr_back #(
        .COORD_BITS (COORD_BITS),
        .PIXEL_BITS (PIXEL_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_data),
        .o_out       (o_out)
    );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives start and advance words through the midpoint circle rasterizer
// under several image sizes and random stalls on both channels. An in-bench
// model of the decision recurrence predicts every point set (addresses,
// color, clip mask, last step), and each point set is checked against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import mcr_pkg::*;

typedef struct {
    logic [ADDR_W-1:0]     addr [NUM_PTS];
    logic [PIXEL_BITS-1:0] pixel;
    logic [NUM_PTS-1:0]    clip;
    logic                  last;
} t_point_set;

class circle_scoreboard;
    bit                         busy;
    logic signed [12:0]         offset_x;
    logic signed [12:0]         offset_y;
    logic signed [17:0]         decision;
    logic [COORD_BITS-1:0]      origin_x;
    logic [COORD_BITS-1:0]      origin_y;
    logic [PIXEL_BITS-1:0]      draw_color;
    logic [CFG_W-1:0]           image_width;
    logic [CFG_W-1:0]           image_height;
    t_point_set                 expected_sets [$];
    int                         errors;
    int                         checked;
    int                         circles_done;

    function new();
        busy         = 1'b0;
        offset_x     = '0;
        offset_y     = '0;
        decision     = '0;
        origin_x     = '0;
        origin_y     = '0;
        draw_color   = '0;
        image_width  = WIDTH_RESET;
        image_height = HEIGHT_RESET;
        errors       = 0;
        checked      = 0;
        circles_done = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        if (idx == REG_IMAGE_WIDTH) begin
            image_width = value;
        end else if (idx == REG_IMAGE_HEIGHT) begin
            image_height = value;
        end
    endfunction

    function void push_set(bit last);
        int         cx;
        int         cy;
        int         x;
        int         y;
        int         px [NUM_PTS];
        int         py [NUM_PTS];
        longint     lin;
        t_point_set s;
        cx = int'(origin_x);
        cy = int'(origin_y);
        x  = int'(offset_x);
        y  = int'(offset_y);
        px[0] = cx + x; py[0] = cy + y;
        px[1] = cx - x; py[1] = cy + y;
        px[2] = cx + x; py[2] = cy - y;
        px[3] = cx - x; py[3] = cy - y;
        px[4] = cx + y; py[4] = cy + x;
        px[5] = cx - y; py[5] = cy + x;
        px[6] = cx + y; py[6] = cy - x;
        px[7] = cx - y; py[7] = cy - x;
        s.clip = '0;
        for (int i = 0; i < NUM_PTS; i++) begin
            if (px[i] < 0 || py[i] < 0 || px[i] >= int'(image_width) ||
                py[i] >= int'(image_height)) begin
                s.clip[i] = 1'b1;
                s.addr[i] = '0;
            end else begin
                lin = longint'(py[i]) * longint'(image_width) + longint'(px[i]);
                s.addr[i] = lin[ADDR_W-1:0];
            end
        end
        s.pixel = draw_color;
        s.last  = last;
        expected_sets.push_back(s);
    endfunction

    // returns 1 when the word yields a point set
    function bit note_word(t_kind kind, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                           logic [COORD_BITS-1:0] r, logic [PIXEL_BITS-1:0] col);
        int ox;
        int oy;
        bit last;
        if (kind == KIND_START) begin
            origin_x   = cx;
            origin_y   = cy;
            draw_color = col;
            offset_x   = '0;
            offset_y   = 13'(r);
            decision   = 18'(DEC_INIT - 2 * int'(r));
            busy       = 1'b1;
            push_set(1'b0);
            return 1'b1;
        end
        if (!busy) begin
            return 1'b0;
        end
        offset_x = offset_x + 13'sd1;
        if (decision > 0) begin
            offset_y = offset_y - 13'sd1;
            ox = int'(offset_x);
            oy = int'(offset_y);
            decision = decision + 18'((ox - oy) * (1 << DEC_GAIN_SH) + DEC_STEP_DIAG);
        end else begin
            ox = int'(offset_x);
            decision = decision + 18'(ox * (1 << DEC_GAIN_SH) + DEC_STEP_AXIS);
        end
        last = offset_y < offset_x;
        if (last) begin
            busy = 1'b0;
            circles_done++;
        end
        push_set(last);
        return 1'b1;
    endfunction

    function void compare(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_set(t_point_set got);
        t_point_set want;
        string      names [NUM_PTS] = '{"addr_a", "addr_b", "addr_c", "addr_d",
                                        "addr_e", "addr_f", "addr_g", "addr_h"};
        if (expected_sets.size() == 0) begin
            $error("point set word with none predicted");
            errors++;
            return;
        end
        want = expected_sets.pop_front();
        checked++;
        for (int i = 0; i < NUM_PTS; i++) begin
            compare(names[i], want.addr[i], got.addr[i]);
        end
        compare("pixel_value", want.pixel, got.pixel);
        compare("clip_mask", want.clip, got.clip);
        compare("last_step", want.last, got.last);
    endfunction
endclass

module testbench;

    localparam int GAP_MAX         = 18;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int WORDS_PER_PHASE = 90;
    localparam int NUM_PHASES      = 7;
    localparam int HOLD_PHASE      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic i_clk;
    logic i_rst_n;

    mcr_in_if  in_if ();
    mcr_out_if out_if ();
    mcr_cfg_if cfg_if ();

    midpoint_circle_rasterizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    circle_scoreboard sb;
    int               words_used = 0;
    int               cycles = 0;
    int               settings_used = 0;
    bit               steady = 1'b0;
    bit               hold_request = 1'b0;
    bit               held_once = 1'b0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic send_word(t_kind kind, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [COORD_BITS-1:0] r, logic [PIXEL_BITS-1:0] col);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.kind     <= kind;
        in_if.center_x <= cx;
        in_if.center_y <= cy;
        in_if.radius   <= r;
        in_if.color    <= col;
        do @(posedge i_clk); while (!in_if.ready);
        if (sb.note_word(kind, cx, cy, r, col)) begin
            words_used++;
        end
    endtask

    task automatic send_advance();
        send_word(KIND_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), PIXEL_BITS'($urandom));
    endtask

    task automatic step_circle(int max_steps);
        int n;
        n = 0;
        while (sb.busy && n < max_steps) begin
            send_advance();
            n++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_SPARE_A, CFG_W'($urandom));
        end
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_SPARE_B, CFG_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.expected_sets.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(int target, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                              bit with_hold);
        int                    base;
        int                    sel;
        int                    r;
        int                    span_x;
        int                    span_y;
        int                    steps;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        base   = words_used;
        span_x = (w == 0) ? 1 : ((w > 4096) ? 4096 : int'(w));
        span_y = (h == 0) ? 1 : ((h > 4096) ? 4096 : int'(h));
        while (words_used - base < target) begin
            steady = ($urandom_range(0, 4) == 0);
            if (!sb.busy && $urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) send_advance();
            end
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                r = $urandom_range(0, 24);
            end else if (sel < 95) begin
                r = $urandom_range(25, 160);
            end else begin
                r = $urandom_range(161, 4095);
            end
            if (with_hold && !held_once && words_used - base > target / 3) begin
                held_once    = 1'b1;
                hold_request = 1'b1;
                steady       = 1'b1;
                r            = 120;
            end
            cx = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
                                             : COORD_BITS'($urandom_range(0, span_x - 1));
            cy = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
                                             : COORD_BITS'($urandom_range(0, span_y - 1));
            send_word(KIND_START, cx, cy, COORD_BITS'(r), PIXEL_BITS'($urandom));
            if (r > 160 || $urandom_range(0, 6) == 0) begin
                steps = $urandom_range(0, 20);
            end else begin
                steps = 1 << 30;
            end
            step_circle(steps);
        end
        steady = 1'b0;
    endtask

    initial begin
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            t_point_set got;
            int         stall;
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                stall = draw_gap();
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got.addr[0] = out_if.addr_a;
            got.addr[1] = out_if.addr_b;
            got.addr[2] = out_if.addr_c;
            got.addr[3] = out_if.addr_d;
            got.addr[4] = out_if.addr_e;
            got.addr[5] = out_if.addr_f;
            got.addr[6] = out_if.addr_g;
            got.addr[7] = out_if.addr_h;
            got.pixel   = out_if.pixel_value;
            got.clip    = out_if.clip_mask;
            got.last    = out_if.last_step;
            sb.check_set(got);
        end
    end

    initial begin
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        sb = new();
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.kind     <= KIND_ADVANCE;
        in_if.center_x <= '0;
        in_if.center_y <= '0;
        in_if.radius   <= '0;
        in_if.color    <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_IMAGE_WIDTH;
        cfg_if.data    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset image size, advance while idle, zero radius, start while busy
        send_advance();
        send_word(KIND_START, 12'd320, 12'd240, 12'd0, 32'h0000_0000);
        send_advance();
        send_advance();
        send_word(KIND_START, 12'd0, 12'd0, 12'd5, 32'hFFFF_FFFF);
        step_circle(2);
        send_word(KIND_START, 12'hFFF, 12'hFFF, 12'hFFF, 32'hA5A5_5A5A);
        step_circle(3);
        send_word(KIND_START, 12'd639, 12'd479, 12'd3, 32'h0F0F_F0F0);
        step_circle(1 << 30);
        send_word(KIND_START, 12'd100, 12'd50, 12'd12, PIXEL_BITS'($urandom));
        step_circle(1 << 30);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin w = 13'd640;  h = 13'd480;  end
                1: begin w = 13'd1;    h = 13'd1;    end
                2: begin w = 13'd4096; h = 13'd4096; end
                3: begin w = 13'd8191; h = 13'd8191; end
                4: begin w = 13'd0;    h = 13'd200;  end
                5: begin w = 13'd300;  h = 13'd0;    end
                default: begin
                    w = CFG_W'($urandom_range(1, 4096));
                    h = CFG_W'($urandom_range(1, 4096));
                end
            endcase
            configure(w, h);
            run_random(WORDS_PER_PHASE, w, h, p == HOLD_PHASE);
            wait_idle();
        end

        if (sb.expected_sets.size() != 0) begin
            $error("%0d point sets never arrived", sb.expected_sets.size());
            sb.errors++;
        end
        $display("covered %0d rasterizer words under %0d image settings plus reset size",
                 words_used, settings_used);
        $display("checked %0d point sets, %0d circles run to their last step",
                 sb.checked, sb.circles_done);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== midpoint_circle_rasterizer.f =====
hdl/mcr_pkg.sv
hdl/mcr_if.sv
hdl/mcr_front.sv
hdl/mcr_queue.sv
hdl/mcr_back.sv
hdl/midpoint_circle_rasterizer.sv
verif/testbench.sv
